// ===== rtl/gdau_pkg.sv =====
// Shared constants, types and calendar tables for the Gregorian date arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package gdau_pkg;

  // Stream widths (fields packed from bit 0 up, padded to whole bytes)
  localparam int unsigned IN_W  = 72;
  localparam int unsigned OUT_W = 56;

  // Pipeline depth: two forward stages, one combine stage, seven inverse
  // stages and the output register
  localparam int unsigned STAGES     = 11;
  localparam int unsigned INV_STAGES = 7;

  // Field widths
  localparam int unsigned YEAR_IN_W = 14;
  localparam int unsigned JDN_W     = 23;
  localparam int unsigned DIFF_W    = 23;
  localparam int unsigned YEAR_W    = 16;
  localparam int unsigned OFS_W     = 23;

  // Operation codes
  typedef enum logic [1:0] {
    MODE_DIFF = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_WDAY = 2'd2
  } mode_e;

  // Divisibility by 25 through the inverse of 25 modulo 2^14
  localparam logic [13:0] INV25     = 14'd7209;
  localparam logic [13:0] DIV25_LIM = 14'((2**14 - 1) / 25);

  // Floor division by 25 of values below 2^13
  localparam int unsigned DIV25_SH  = 17;
  localparam logic [12:0] DIV25_MUL = 13'((2**17 + 24) / 25);

  // Forward conversion offsets
  localparam logic [23:0] JDN_OFS   = 24'd32045;
  localparam logic [14:0] YEAR_SHIFT = 15'd4800;

  // Inverse conversion constants
  localparam longint unsigned ERA_DAYS  = 64'd146097;
  localparam longint unsigned QUAD_DAYS = 64'd1461;
  localparam logic [24:0] CIV_OFS   = 25'd32044;
  // 100 eras of bias keep the first quotient non-negative
  localparam logic [25:0] ERA_BIAS  = 26'(64'd100 * ERA_DAYS);
  localparam logic [25:0] C_BIAS    = 26'(64'd25 * ERA_DAYS);
  localparam logic [15:0] YEAR_BIAS = 16'd14800;

  localparam int unsigned RECIP1_SH = 44;
  localparam logic [26:0] RECIP1_MUL =
    27'(((64'd1 << RECIP1_SH) + ERA_DAYS - 64'd1) / ERA_DAYS);
  localparam int unsigned RECIP2_SH = 29;
  localparam logic [18:0] RECIP2_MUL =
    19'(((64'd1 << RECIP2_SH) + QUAD_DAYS - 64'd1) / QUAD_DAYS);
  localparam int unsigned RECIP3_SH = 19;
  localparam logic [11:0] RECIP3_MUL = 12'(((64'd1 << RECIP3_SH) + 64'd152) / 64'd153);

  // Day offset of a month counted from March, (153*m+2)/5
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] res;
    case (idx)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // Length of a month in a common year; zero for a month code out of range
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] res;
    case (month)
      4'd1:    res = 5'd31;
      4'd2:    res = 5'd28;
      4'd3:    res = 5'd31;
      4'd4:    res = 5'd30;
      4'd5:    res = 5'd31;
      4'd6:    res = 5'd30;
      4'd7:    res = 5'd31;
      4'd8:    res = 5'd31;
      4'd9:    res = 5'd30;
      4'd10:   res = 5'd31;
      4'd11:   res = 5'd30;
      4'd12:   res = 5'd31;
      default: res = 5'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gdau_ctrl.sv =====
// Valid-bit chain and per-stage load enables of the date pipeline.
`timescale 1ns / 1ps
`default_nettype none

module gdau_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [gdau_pkg::STAGES-1:0]        en_o
);

  localparam int unsigned Last = gdau_pkg::STAGES - 1;

  logic [gdau_pkg::STAGES-1:0] v_q, v_d;
  logic [gdau_pkg::STAGES-1:0] en;

  // A stage loads when it is empty or its contents move on
  always_comb begin
    en[Last] = !v_q[Last] || out_ready_i;
    for (int k = int'(Last) - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // Advance valid bits along with the payload
  always_comb begin
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < int'(gdau_pkg::STAGES); k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign en_o        = en;
  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[Last];

endmodule

`default_nettype wire

// ===== rtl/gdau_fwd.sv =====
// Two-stage date check and date-to-day-number conversion for one date.
`timescale 1ns / 1ps
`default_nettype none

module gdau_fwd (
  input  wire logic                              clk_i,
  input  wire logic [1:0]                        en_i,
  input  wire logic [gdau_pkg::YEAR_IN_W-1:0]    year_i,
  input  wire logic [3:0]                        month_i,
  input  wire logic [4:0]                        day_i,
  output logic [gdau_pkg::JDN_W-1:0]             jdn_o,
  output logic                                   ok_o
);

  // Stage 0 terms
  logic        early;
  logic [14:0] y_ext;
  logic [3:0]  mi;
  logic [8:0]  dterm_d, dterm_q;
  logic [23:0] y365_d, y365_q;
  logic [12:0] q4_d, q4_q;
  logic [24:0] p100;
  logic [22:0] p400;
  logic [7:0]  q100_d, q100_q;
  logic [5:0]  q400_d, q400_q;
  logic [13:0] inv_prod;
  logic        div25;
  logic        leap_d, leap_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;

  // Stage 1 terms
  logic [4:0]  lim;
  logic        ok_d, ok_q;
  logic [23:0] jdn_sum;
  logic [gdau_pkg::JDN_W-1:0] jdn_q;

  // Shift the year to start in March and split it into the leap-day terms
  always_comb begin
    early    = (month_i <= 4'd2);
    y_ext    = {1'b0, year_i} + gdau_pkg::YEAR_SHIFT - {14'd0, early};
    mi       = early ? month_i + 4'd9 : month_i - 4'd3;
    dterm_d  = {4'd0, day_i} + gdau_pkg::month_start(mi);
    y365_d   = 24'(y_ext) * 24'd365;
    q4_d     = y_ext[14:2];
    p100     = 25'(q4_d) * 25'(gdau_pkg::DIV25_MUL);
    p400     = 23'(y_ext[14:4]) * 23'(gdau_pkg::DIV25_MUL);
    q100_d   = p100[24:gdau_pkg::DIV25_SH];
    q400_d   = p400[22:gdau_pkg::DIV25_SH];
  end

  // Leap year: divisible by 4 and not by 100, or divisible by 400
  always_comb begin
    inv_prod = year_i * gdau_pkg::INV25;
    div25    = (inv_prod <= gdau_pkg::DIV25_LIM);
    leap_d   = (year_i[1:0] == 2'd0) && (!div25 || (year_i[3:0] == 4'd0));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      month_q <= month_i;
      day_q   <= day_i;
      leap_q  <= leap_d;
      dterm_q <= dterm_d;
      y365_q  <= y365_d;
      q4_q    <= q4_d;
      q100_q  <= q100_d;
      q400_q  <= q400_d;
    end
  end

  // Check the date and sum the day number
  always_comb begin
    lim = ((month_q == 4'd2) && leap_q) ? 5'd29 : gdau_pkg::month_len(month_q);
    ok_d = (month_q inside {[4'd1:4'd12]}) && (day_q != 5'd0) && (day_q <= lim);
    jdn_sum = 24'(dterm_q) + y365_q + 24'(q4_q) + 24'(q400_q) - 24'(q100_q)
              - gdau_pkg::JDN_OFS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ok_q  <= ok_d;
      jdn_q <= jdn_sum[gdau_pkg::JDN_W-1:0];
    end
  end

  assign jdn_o = jdn_q;
  assign ok_o  = ok_q;

endmodule

`default_nettype wire

// ===== rtl/gdau_inv.sv =====
// Seven-stage day-number-to-date conversion with constant reciprocal multiplies.
`timescale 1ns / 1ps
`default_nettype none

module gdau_inv (
  input  wire logic                               clk_i,
  input  wire logic [gdau_pkg::INV_STAGES-1:0]    en_i,
  input  wire logic signed [24:0]                 a_i,
  input  wire logic [25:0]                        n1_i,
  output logic signed [gdau_pkg::YEAR_W-1:0]      year_o,
  output logic [3:0]                              month_o,
  output logic [4:0]                              day_o
);

  // Era quotient
  logic [52:0]        p1_q;
  logic signed [24:0] a3_q, a4_q;
  logic [8:0]         qb;
  logic [8:0]         qb4_q, qb5_q, qb6_q;
  logic [25:0]        t_d, t_q;
  // Day of era
  logic signed [25:0] c_w;
  logic [15:0]        c5_q, c6_q, c7_q;
  logic [36:0]        p2_q;
  // Year of era
  logic [6:0]         q;
  logic [17:0]        t2_d, t2_q;
  logic [15:0]        yb_d, yb7_q, yb8_q, yb9_q;
  // Day of year and month
  logic [15:0]        e_w;
  logic [8:0]         e8_q, e9_q;
  logic [10:0]        e5;
  logic [22:0]        p3_q;
  logic [3:0]         m1;
  logic               wrap;
  logic [8:0]         day_w;

  // Quotient by the 400-year era length
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p1_q <= 53'(n1_i) * 53'(gdau_pkg::RECIP1_MUL);
      a3_q <= a_i;
    end
  end

  // Days consumed by whole eras
  always_comb begin
    qb  = p1_q[52:gdau_pkg::RECIP1_SH];
    t_d = 26'(27'(qb) * 27'(gdau_pkg::ERA_DAYS));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      t_q   <= t_d;
      qb4_q <= qb;
      a4_q  <= a3_q;
    end
  end

  // Remainder within the era
  always_comb begin
    c_w = 26'(a4_q) + $signed(gdau_pkg::C_BIAS) - $signed({2'b00, t_q[25:2]});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      c5_q  <= c_w[15:0];
      qb5_q <= qb4_q;
    end
  end

  // Quotient by the four-year cycle length
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      p2_q  <= 37'({c5_q, 2'b11}) * 37'(gdau_pkg::RECIP2_MUL);
      c6_q  <= c5_q;
      qb6_q <= qb5_q;
    end
  end

  // Days of whole four-year cycles and the year before the month wrap
  always_comb begin
    q    = p2_q[35:gdau_pkg::RECIP2_SH];
    t2_d = 18'(q) * 18'(gdau_pkg::QUAD_DAYS);
    yb_d = 16'(qb6_q) * 16'd100 + 16'(q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      t2_q  <= t2_d;
      c7_q  <= c6_q;
      yb7_q <= yb_d;
    end
  end

  // Day of the March-based year
  always_comb begin
    e_w = c7_q - 16'(t2_q[17:2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      e8_q  <= e_w[8:0];
      yb8_q <= yb7_q;
    end
  end

  // Month index from the day of year
  always_comb begin
    e5 = 11'({e8_q, 2'b00}) + 11'(e8_q) + 11'd2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      p3_q  <= 23'(e5) * 23'(gdau_pkg::RECIP3_MUL);
      e9_q  <= e8_q;
      yb9_q <= yb8_q;
    end
  end

  // Map back to a January-based calendar
  always_comb begin
    m1      = p3_q[22:gdau_pkg::RECIP3_SH];
    wrap    = (m1 >= 4'd10);
    day_w   = e9_q - gdau_pkg::month_start(m1) + 9'd1;
    day_o   = day_w[4:0];
    month_o = wrap ? m1 - 4'd9 : m1 + 4'd3;
    year_o  = $signed(yb9_q - gdau_pkg::YEAR_BIAS + 16'(wrap));
  end

endmodule

`default_nettype wire

// ===== rtl/gregorian_date_arithmetic_unit.sv =====
// Top level of the Gregorian date arithmetic unit: stream ports, combine and output stages.
`timescale 1ns / 1ps
`default_nettype none

// Gregorian date unit on streaming ports. Each transaction carries a mode, two
// dates and a signed day offset; mode 0 returns the day difference (second
// minus first, saturated to 23 signed bits), mode 1 the first date plus the
// offset, mode 2 the weekday of the first date with Sunday as 0. A result in
// mode 0 with either date failing the month/day/leap check, in mode 1 or 2
// with the first date failing it, or in mode 3, has every field zero. The unit
// takes one transaction per clock while the output does not stall and returns
// results in order through two forward conversion stages, one combine stage,
// seven stages of constant reciprocal multiplies in the day-number-to-date
// conversion and the output register. Backpressure on the output stops only
// the stages that are full, so bubbles are squeezed out while a result waits.
module gregorian_date_arithmetic_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // mode[1:0], first_year[15:2], first_month[19:16], first_day[24:20],
  // second_year[38:25], second_month[42:39], second_day[47:43],
  // offset_days[70:48], zero[71]
  input  wire logic [gdau_pkg::IN_W-1:0]   s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // valid_res[0], day_difference[23:1], result_year[39:24],
  // result_month[43:40], result_day[48:44], weekday[51:49], zero[55:52]
  output logic [gdau_pkg::OUT_W-1:0]       m_axis_tdata_o
);

  typedef struct packed {
    gdau_pkg::mode_e                 mode;
    logic                            ok;
    logic [gdau_pkg::DIFF_W-1:0]     diff;
    logic [2:0]                      wday;
  } side_t;

  logic [gdau_pkg::STAGES-1:0] en;

  // Input fields
  logic [1:0]                         in_mode;
  logic [gdau_pkg::YEAR_IN_W-1:0]     in_y1, in_y2;
  logic [3:0]                         in_m1, in_m2;
  logic [4:0]                         in_d1, in_d2;
  logic signed [gdau_pkg::OFS_W-1:0]  in_ofs;

  // Stages 0 and 1 side data
  gdau_pkg::mode_e                    mode0_q, mode1_q;
  logic signed [gdau_pkg::OFS_W-1:0]  ofs0_q, ofs1_q;

  // Forward results
  logic [gdau_pkg::JDN_W-1:0] jdn1, jdn2;
  logic                       ok1, ok2;

  // Stage 2
  logic                       valid_d;
  logic signed [23:0]         diff_w;
  logic [gdau_pkg::DIFF_W-1:0] diff_d;
  logic [23:0]                jdn1_ext;
  logic [5:0]                 oct_sum;
  logic [3:0]                 fold1;
  logic [2:0]                 fold2;
  logic [2:0]                 rem7;
  logic [2:0]                 wday_d;
  logic signed [24:0]         a_d, a_q;
  logic [25:0]                n1_d, n1_q;
  side_t                      side2_d;
  side_t                      side_q [2:9];

  // Inverse results and output
  logic signed [gdau_pkg::YEAR_W-1:0] inv_year;
  logic [3:0]                         inv_month;
  logic [4:0]                         inv_day;
  logic [gdau_pkg::OUT_W-1:0]         out_d, out_q;

  gdau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .en_o        (en)
  );

  // Unpack the input transaction
  assign in_mode = s_axis_tdata_i[1:0];
  assign in_y1   = s_axis_tdata_i[15:2];
  assign in_m1   = s_axis_tdata_i[19:16];
  assign in_d1   = s_axis_tdata_i[24:20];
  assign in_y2   = s_axis_tdata_i[38:25];
  assign in_m2   = s_axis_tdata_i[42:39];
  assign in_d2   = s_axis_tdata_i[47:43];
  assign in_ofs  = $signed(s_axis_tdata_i[70:48]);

  gdau_fwd u_fwd_first (
    .clk_i   (clk_i),
    .en_i    (en[1:0]),
    .year_i  (in_y1),
    .month_i (in_m1),
    .day_i   (in_d1),
    .jdn_o   (jdn1),
    .ok_o    (ok1)
  );

  gdau_fwd u_fwd_second (
    .clk_i   (clk_i),
    .en_i    (en[1:0]),
    .year_i  (in_y2),
    .month_i (in_m2),
    .day_i   (in_d2),
    .jdn_o   (jdn2),
    .ok_o    (ok2)
  );

  // Carry mode and offset beside the forward conversion
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mode0_q <= gdau_pkg::mode_e'(in_mode);
      ofs0_q  <= in_ofs;
    end
    if (en[1]) begin
      mode1_q <= mode0_q;
      ofs1_q  <= ofs0_q;
    end
  end

  // Result validity per operation
  always_comb begin
    case (mode1_q)
      gdau_pkg::MODE_DIFF: valid_d = ok1 && ok2;
      gdau_pkg::MODE_ADD:  valid_d = ok1;
      gdau_pkg::MODE_WDAY: valid_d = ok1;
      default:             valid_d = 1'b0;
    endcase
  end

  // Saturated day difference
  always_comb begin
    diff_w = $signed({1'b0, jdn2}) - $signed({1'b0, jdn1});
    if (diff_w > 24'sd4194303) begin
      diff_d = {1'b0, {(gdau_pkg::DIFF_W-1){1'b1}}};
    end else if (diff_w < -24'sd4194304) begin
      diff_d = {1'b1, {(gdau_pkg::DIFF_W-1){1'b0}}};
    end else begin
      diff_d = diff_w[gdau_pkg::DIFF_W-1:0];
    end
  end

  // Day number mod 7 by folding octal digits, then shift to Sunday = 0
  always_comb begin
    jdn1_ext = {1'b0, jdn1};
    oct_sum  = '0;
    for (int k = 0; k < 8; k++) begin
      oct_sum = oct_sum + 6'(jdn1_ext[3*k +: 3]);
    end
    fold1  = 4'(oct_sum[5:3]) + 4'(oct_sum[2:0]);
    fold2  = fold1[2:0] + 3'(fold1[3]);
    rem7   = (fold2 == 3'd7) ? 3'd0 : fold2;
    wday_d = (rem7 == 3'd6) ? 3'd0 : rem7 + 3'd1;
  end

  // Shifted sum and the first numerator of the inverse conversion
  always_comb begin
    a_d  = $signed({2'b00, jdn1}) + 25'(ofs1_q) + $signed(gdau_pkg::CIV_OFS);
    n1_d = 26'({a_d, 2'b11}) + gdau_pkg::ERA_BIAS;
  end

  always_comb begin
    side2_d.mode = mode1_q;
    side2_d.ok   = valid_d;
    side2_d.diff = diff_d;
    side2_d.wday = wday_d;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      side_q[2] <= side2_d;
      a_q       <= a_d;
      n1_q      <= n1_d;
    end
  end

  // Delay line for mode results beside the inverse conversion
  always_ff @(posedge clk_i) begin
    for (int k = 3; k <= 9; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  gdau_inv u_inv (
    .clk_i   (clk_i),
    .en_i    (en[9:3]),
    .a_i     (a_q),
    .n1_i    (n1_q),
    .year_o  (inv_year),
    .month_o (inv_month),
    .day_o   (inv_day)
  );

  // Select the fields of the operation; zero everything on an invalid date or mode 3
  always_comb begin
    out_d = '0;
    if (side_q[9].ok) begin
      out_d[0] = 1'b1;
      case (side_q[9].mode)
        gdau_pkg::MODE_DIFF: out_d[23:1] = side_q[9].diff;
        gdau_pkg::MODE_ADD: begin
          out_d[39:24] = inv_year;
          out_d[43:40] = inv_month;
          out_d[48:44] = inv_day;
        end
        gdau_pkg::MODE_WDAY: out_d[51:49] = side_q[9].wday;
        default:             out_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata_o = out_q;

endmodule

`default_nettype wire
